/* sv/csem_pkg.sv */
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Field widths, operation and status codes, and sequencer states for the
// semaphore table; its checker and testbench import the package as well.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csem_pkg;

  localparam int OP_W      = 2;
  localparam int PROC_ID_W = 6;
  localparam int SEM_ID_W  = 4;
  localparam int VALUE_W   = 16;
  localparam int REF_W     = 8;
  localparam int STATUS_W  = 3;

  localparam logic [REF_W-1:0]   REF_MAX   = '1;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_GET  = 2'd0,
    OP_FREE = 2'd1,
    OP_DOWN = 2'd2,
    OP_UP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_IN_USE = 3'd1,
    ST_NO_SLOT    = 3'd2,
    ST_FULL       = 3'd3,
    ST_BAD_ID     = 3'd4,
    ST_NOT_HELD   = 3'd5,
    ST_BLOCK      = 3'd6,
    ST_REF_FULL   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EXEC = 2'd2
  } state_t;

endpackage

`default_nettype wire

/* sv/csem_ffs.sv */
// ----------------------------------------------------------------------------
// Find first set
// Priority encoder: reports whether any request bit is set and the index of
// the lowest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csem_ffs #(
  parameter int N = 16
) (
  input  logic [N-1:0]                       req,
  output logic                               found,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);

  localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/counting_semaphore_table_unit.sv */
// ----------------------------------------------------------------------------
// Counting semaphore table unit
// Bank of counting semaphores with reference counts and per-process holder
// slots, kept in two synchronous memories.
//
// Usage:
//   Request channel (in_valid/in_ready) carries op, proc_id, sem_id, create
//   and init_value. Response channel (out_valid/out_ready) returns status,
//   sem_index and wake, exactly one response per request, in order.
//   One request is processed at a time: accept, read both memories, then
//   modify and write back while loading the response register. in_ready
//   returns at the same edge that raises out_valid, so a new request is
//   taken only once the last one has passed its read and write-back
//   states.
//   A new request is taken while a response still waits; it stalls in its
//   write-back cycle until the waiting response is taken, so a stalled
//   receiver holds the response stable and blocks at most one request.
//   Reset clears all entries to free and all holder slots to empty at once
//   through per-entry and per-process valid bits; the unit accepts a
//   request in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_table_unit #(
  parameter int NUM_SEMS       = 16,
  parameter int SLOTS_PER_PROC = 8,
  parameter int NUM_PROCS      = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csem_pkg::OP_W-1:0]     op,
  input  logic [csem_pkg::PROC_ID_W-1:0] proc_id,
  input  logic [csem_pkg::SEM_ID_W-1:0] sem_id,
  input  logic                          create,
  input  logic [csem_pkg::VALUE_W-1:0]  init_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csem_pkg::STATUS_W-1:0] status,
  output logic [csem_pkg::SEM_ID_W-1:0] sem_index,
  output logic                          wake
);

  import csem_pkg::*;

  localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int SLOT_W = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1;
  localparam int ROW_W  = SLOTS_PER_PROC * (1 + SEM_W);
  localparam int WORD_W = REF_W + VALUE_W;

  state_t state, state_next;

  op_t                  req_op;
  logic [PROC_ID_W-1:0] req_proc;
  logic [SEM_ID_W-1:0]  req_sid;
  logic                 req_create;
  logic [VALUE_W-1:0]   req_init;

  logic             free_any, free_any_c;
  logic [SEM_W-1:0] free_idx, free_idx_c;

  logic [NUM_SEMS-1:0]  in_use;
  logic [NUM_PROCS-1:0] row_init;

  logic [WORD_W-1:0] sem_mem [NUM_SEMS];
  logic [ROW_W-1:0]  row_mem [NUM_PROCS];

  logic [WORD_W-1:0] sem_q;
  logic [ROW_W-1:0]  row_q;
  logic              row_ok;
  logic              use_ok;
  logic [SEM_W-1:0]  sem_addr;
  logic [PROC_W-1:0] proc_addr;

  logic             is_create;
  logic             sid_ok;
  logic             proc_ok;
  logic [SEM_W-1:0] rd_sem_addr;
  logic             ex_go;

  logic [SLOTS_PER_PROC-1:0]            rv, new_rv, match;
  logic [SLOTS_PER_PROC-1:0][SEM_W-1:0] rs, new_rs;
  logic                                 slot_found, match_found;
  logic [SLOT_W-1:0]                    slot_idx, match_idx;

  logic [REF_W-1:0]   cur_ref;
  logic [VALUE_W-1:0] cur_val;

  status_t           st_c;
  logic [SEM_ID_W-1:0] idx_c;
  logic              wake_c;
  logic              sem_we, row_we, use_set, use_clr;
  logic [WORD_W-1:0] sem_wdata;
  logic [ROW_W-1:0]  row_wdata;

  csem_ffs #(.N(NUM_SEMS)) u_free (
    .req   (~in_use),
    .found (free_any_c),
    .idx   (free_idx_c)
  );

  csem_ffs #(.N(SLOTS_PER_PROC)) u_slot (
    .req   (~rv),
    .found (slot_found),
    .idx   (slot_idx)
  );

  csem_ffs #(.N(SLOTS_PER_PROC)) u_match (
    .req   (match),
    .found (match_found),
    .idx   (match_idx)
  );

  assign is_create   = (req_op == OP_GET) && req_create;
  assign sid_ok      = 32'(req_sid) < NUM_SEMS;
  assign proc_ok     = 32'(req_proc) < NUM_PROCS;
  assign rd_sem_addr = is_create ? free_idx : SEM_W'(req_sid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ex_go      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ex_go = !out_valid || out_ready;
        if (ex_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op     <= op_t'(op);
      req_proc   <= proc_id;
      req_sid    <= sem_id;
      req_create <= create;
      req_init   <= init_value;
      free_any   <= free_any_c;
      free_idx   <= free_idx_c;
    end
    if (state == S_READ) begin
      sem_addr  <= rd_sem_addr;
      proc_addr <= PROC_W'(req_proc);
      row_ok    <= proc_ok ? row_init[PROC_W'(req_proc)] : 1'b0;
      use_ok    <= sid_ok ? in_use[SEM_W'(req_sid)] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go && sem_we) begin
      sem_mem[sem_addr] <= sem_wdata;
    end
    if (state == S_READ) begin
      sem_q <= sem_mem[rd_sem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go && row_we) begin
      row_mem[proc_addr] <= row_wdata;
    end
    if (state == S_READ) begin
      row_q <= row_mem[PROC_W'(req_proc)];
    end
  end

  assign rv      = row_q[SLOTS_PER_PROC-1:0] & {SLOTS_PER_PROC{row_ok}};
  assign rs      = row_q[ROW_W-1:SLOTS_PER_PROC];
  assign cur_ref = sem_q[WORD_W-1:VALUE_W];
  assign cur_val = sem_q[VALUE_W-1:0];

  always_comb begin
    for (int i = 0; i < SLOTS_PER_PROC; i++) begin
      match[i] = rv[i] && (rs[i] == sem_addr);
    end
  end

  always_comb begin
    st_c      = ST_OK;
    idx_c     = req_sid;
    wake_c    = 1'b0;
    sem_we    = 1'b0;
    row_we    = 1'b0;
    use_set   = 1'b0;
    use_clr   = 1'b0;
    sem_wdata = sem_q;
    new_rv    = rv;
    new_rs    = rs;
    if (is_create) begin
      if (!free_any) begin
        st_c = ST_FULL;
      end else if (!proc_ok || !slot_found) begin
        st_c = ST_NO_SLOT;
      end else begin
        sem_we           = 1'b1;
        sem_wdata        = {REF_W'(1), req_init};
        new_rv[slot_idx] = 1'b1;
        new_rs[slot_idx] = sem_addr;
        row_we           = 1'b1;
        use_set          = 1'b1;
        idx_c            = SEM_ID_W'(sem_addr);
      end
    end else if (!sid_ok) begin
      st_c = ST_BAD_ID;
    end else if (!use_ok) begin
      st_c = ST_NOT_IN_USE;
    end else begin
      case (req_op)
        OP_GET: begin
          if (cur_ref == REF_MAX) begin
            st_c = ST_REF_FULL;
          end else begin
            sem_we    = 1'b1;
            sem_wdata = {cur_ref + REF_W'(1), cur_val};
          end
        end
        OP_FREE: begin
          if (!match_found) begin
            st_c = ST_NOT_HELD;
          end else begin
            sem_we            = 1'b1;
            sem_wdata         = {cur_ref - REF_W'(1), cur_val};
            new_rv[match_idx] = 1'b0;
            row_we            = 1'b1;
            use_clr           = (cur_ref == REF_W'(1));
          end
        end
        OP_DOWN: begin
          if (cur_val == '0) begin
            st_c = ST_BLOCK;
          end else begin
            sem_we    = 1'b1;
            sem_wdata = {cur_ref, cur_val - VALUE_W'(1)};
          end
        end
        OP_UP: begin
          if (cur_val != VALUE_MAX) begin
            sem_we    = 1'b1;
            sem_wdata = {cur_ref, cur_val + VALUE_W'(1)};
            wake_c    = (cur_val == '0);
          end
        end
        default: begin
          st_c = ST_OK;
        end
      endcase
    end
    row_wdata = {new_rs, new_rv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= '0;
      row_init <= '0;
    end else if (ex_go) begin
      if (use_set) begin
        in_use[sem_addr] <= 1'b1;
      end
      if (use_clr) begin
        in_use[sem_addr] <= 1'b0;
      end
      if (row_we) begin
        row_init[proc_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go) begin
      status    <= st_c;
      sem_index <= idx_c;
      wake      <= wake_c;
    end
  end

endmodule

`default_nettype wire

/* sv/csem_checker.sv */
// ----------------------------------------------------------------------------
// Counting semaphore table checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csem_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [csem_pkg::STATUS_W-1:0] status,
  input wire logic                          wake
);

  import csem_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(wake))
    else $error("response dropped or changed while stalled");

  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake |-> status == ST_OK)
    else $error("wake with error status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("unit not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule

bind counting_semaphore_table_unit csem_checker u_csem_checker (.*);

`default_nettype wire

/* bench/counting_semaphore_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// Counting semaphore table unit testbench
// Drives get, free, down and up requests through the request channel and
// checks every response against a local model of the entry table and the
// per-process holder slots. Directed tests cover the saturation corners and
// every error code but ST_BAD_ID, then a long response stall backs the unit
// up, then random traffic runs with idle gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module counting_semaphore_table_unit_tb;
  import csem_pkg::*;

  localparam int NUM_SEMS       = 16;
  localparam int SLOTS_PER_PROC = 8;
  localparam int NUM_PROCS      = 64;
  localparam int RANDOM_ITEMS   = 600;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct packed {
    status_t             status;
    logic [SEM_ID_W-1:0] sem_index;
    logic                wake;
  } sem_rsp_t;

  typedef struct packed {
    logic [PROC_ID_W-1:0] proc;
    logic [SEM_ID_W-1:0]  sem;
  } holder_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  op_t                  op         = OP_GET;
  logic [PROC_ID_W-1:0] proc_id    = '0;
  logic [SEM_ID_W-1:0]  sem_id     = '0;
  logic                 create     = 1'b0;
  logic [VALUE_W-1:0]   init_value = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [SEM_ID_W-1:0]  sem_index;
  logic                 wake;

  bit   [REF_W-1:0]    sem_refs     [NUM_SEMS];
  logic [VALUE_W-1:0]  sem_value    [NUM_SEMS];
  bit                  holder_valid [NUM_PROCS][SLOTS_PER_PROC];
  bit   [SEM_ID_W-1:0] holder_sem   [NUM_PROCS][SLOTS_PER_PROC];

  sem_rsp_t pending_rsp_q[$];
  holder_t  held_q[$];
  int       errors      = 0;
  int       cycles      = 0;
  int       rx_hold     = 0;
  int       leak_budget = 3;
  bit       fast_send   = 1'b0;
  bit       steady_flow = 1'b0;

  counting_semaphore_table_unit #(
    .NUM_SEMS(NUM_SEMS),
    .SLOTS_PER_PROC(SLOTS_PER_PROC),
    .NUM_PROCS(NUM_PROCS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .proc_id(proc_id),
    .sem_id(sem_id),
    .create(create),
    .init_value(init_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .sem_index(sem_index),
    .wake(wake)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic sem_rsp_t apply_request(op_t req_op, logic [PROC_ID_W-1:0] proc,
      logic [SEM_ID_W-1:0] sem, logic req_create, logic [VALUE_W-1:0] initv);
    sem_rsp_t rsp;
    holder_t  h;
    int       entry;
    int       slot;
    rsp.status    = ST_OK;
    rsp.sem_index = sem;
    rsp.wake      = 1'b0;
    entry         = -1;
    slot          = -1;
    if (req_op == OP_GET && req_create) begin
      for (int i = NUM_SEMS - 1; i >= 0; i--)
        if (sem_refs[i] == '0) entry = i;
      if (entry < 0) begin
        rsp.status = ST_FULL;
      end else begin
        if (int'(proc) < NUM_PROCS)
          for (int i = SLOTS_PER_PROC - 1; i >= 0; i--)
            if (!holder_valid[proc][i]) slot = i;
        if (slot < 0) begin
          rsp.status = ST_NO_SLOT;
        end else begin
          sem_refs[entry]          = REF_W'(1);
          sem_value[entry]         = initv;
          holder_valid[proc][slot] = 1'b1;
          holder_sem[proc][slot]   = entry[SEM_ID_W-1:0];
          rsp.sem_index            = entry[SEM_ID_W-1:0];
          h.proc                   = proc;
          h.sem                    = entry[SEM_ID_W-1:0];
          held_q.push_back(h);
        end
      end
    end else if (int'(sem) >= NUM_SEMS) begin
      rsp.status = ST_BAD_ID;
    end else if (sem_refs[sem] == '0) begin
      rsp.status = ST_NOT_IN_USE;
    end else begin
      case (req_op)
        OP_GET: begin
          if (sem_refs[sem] == REF_MAX) rsp.status = ST_REF_FULL;
          else sem_refs[sem] = sem_refs[sem] + 1'b1;
        end
        OP_FREE: begin
          if (int'(proc) < NUM_PROCS)
            for (int i = SLOTS_PER_PROC - 1; i >= 0; i--)
              if (holder_valid[proc][i] && holder_sem[proc][i] == sem) slot = i;
          if (slot < 0) begin
            rsp.status = ST_NOT_HELD;
          end else begin
            sem_refs[sem]            = sem_refs[sem] - 1'b1;
            holder_valid[proc][slot] = 1'b0;
            for (int i = held_q.size() - 1; i >= 0; i--)
              if (held_q[i].proc == proc && held_q[i].sem == sem) held_q.delete(i);
          end
        end
        OP_DOWN: begin
          if (sem_value[sem] == '0) rsp.status = ST_BLOCK;
          else sem_value[sem] = sem_value[sem] - 1'b1;
        end
        default: begin
          if (sem_value[sem] != VALUE_MAX) begin
            sem_value[sem] = sem_value[sem] + 1'b1;
            if (sem_value[sem] == 1) rsp.wake = 1'b1;
          end
        end
      endcase
    end
    return rsp;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return VALUE_W'(1);
      2:       return VALUE_MAX;
      3:       return VALUE_MAX - 1'b1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_request(op_t req_op, logic [PROC_ID_W-1:0] proc,
      logic [SEM_ID_W-1:0] sem, logic req_create, logic [VALUE_W-1:0] initv);
    int gap;
    bit taken;
    gap = (fast_send || steady_flow) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op         <= req_op;
    proc_id    <= proc;
    sem_id     <= sem;
    create     <= req_create;
    init_value <= initv;
    in_valid   <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pending_rsp_q.push_back(apply_request(req_op, proc, sem, req_create, initv));
  endtask

  task automatic wait_for_responses();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_ops();
    send_request(OP_UP, 6'd0, 4'd3, 1'b0, 16'd0);
    send_request(OP_DOWN, 6'd0, 4'd3, 1'b0, 16'd0);
    send_request(OP_FREE, 6'd0, 4'd3, 1'b1, 16'd0);
    send_request(OP_GET, 6'd0, 4'd15, 1'b0, VALUE_MAX);
    send_request(OP_GET, 6'd0, 4'd15, 1'b1, 16'd0);
    send_request(OP_DOWN, 6'd0, 4'd0, 1'b0, 16'd0);
    send_request(OP_UP, 6'd0, 4'd0, 1'b0, 16'd0);
    send_request(OP_UP, 6'd0, 4'd0, 1'b0, 16'd0);
    send_request(OP_DOWN, 6'd0, 4'd0, 1'b0, 16'd0);
    send_request(OP_GET, 6'd7, 4'd0, 1'b0, 16'd0);
    send_request(OP_GET, 6'd63, 4'd0, 1'b1, VALUE_MAX);
    send_request(OP_UP, 6'd63, 4'd1, 1'b0, 16'd0);
    send_request(OP_DOWN, 6'd63, 4'd1, 1'b1, VALUE_MAX);
    send_request(OP_FREE, 6'd1, 4'd1, 1'b0, 16'd0);
    send_request(OP_FREE, 6'd63, 4'd1, 1'b0, 16'd0);
  endtask

  task automatic test_holder_slots_full();
    for (int i = 0; i <= SLOTS_PER_PROC; i++)
      send_request(OP_GET, 6'd5, 4'($urandom), 1'b1, pick_value());
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 8; i++)
      send_request(OP_GET, 6'd6, 4'($urandom), 1'b1, pick_value());
    send_request(OP_GET, 6'd5, 4'd0, 1'b1, 16'h8000);
  endtask

  task automatic release_held();
    holder_t snapshot[$];
    snapshot = held_q;
    foreach (snapshot[i])
      if (snapshot[i].sem != '0) send_request(OP_FREE, snapshot[i].proc, snapshot[i].sem, 1'b0, '0);
  endtask

  task automatic test_refcount_full();
    while (sem_refs[0] != REF_MAX)
      send_request(OP_GET, 6'($urandom), 4'd0, 1'b0, 16'($urandom));
    send_request(OP_GET, 6'd42, 4'd0, 1'b0, 16'h7FFF);
  endtask

  task automatic test_backpressure();
    rx_hold   = 120;
    fast_send = 1'b1;
    for (int i = 0; i < 10; i++)
      send_request((i % 2 == 0) ? OP_UP : OP_DOWN, 6'd0, 4'd0, 1'b0, '0);
    fast_send = 1'b0;
  endtask

  task automatic test_random_traffic();
    op_t                  r_op;
    logic [PROC_ID_W-1:0] proc;
    logic [SEM_ID_W-1:0]  sem;
    logic                 r_create;
    logic [VALUE_W-1:0]   initv;
    holder_t              h;
    int                   pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= 400 && n < 480);
      pick        = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) proc = PROC_ID_W'($urandom_range(0, 3));
      else proc = PROC_ID_W'($urandom);
      sem      = SEM_ID_W'($urandom);
      r_create = 1'($urandom);
      initv    = pick_value();
      if (pick < 30) begin
        r_op     = OP_GET;
        r_create = 1'b1;
      end else if (pick < 55) begin
        r_op = OP_FREE;
        if (held_q.size() != 0 && $urandom_range(0, 9) < 8) begin
          h    = held_q[$urandom_range(0, held_q.size() - 1)];
          proc = h.proc;
          sem  = h.sem;
        end
      end else if (pick < 95) begin
        r_op = (pick < 75) ? OP_DOWN : OP_UP;
        if (held_q.size() != 0 && $urandom_range(0, 9) < 8)
          sem = held_q[$urandom_range(0, held_q.size() - 1)].sem;
      end else begin
        r_op     = OP_GET;
        r_create = 1'b0;
        if (sem_refs[sem] != '0 && sem_refs[sem] != REF_MAX) begin
          if (leak_budget > 0) leak_budget--;
          else sem = '0;
        end
      end
      send_request(r_op, proc, sem, r_create, initv);
    end
    steady_flow = 1'b0;
  endtask

  initial begin : response_checker
    int       stall;
    bit       hit;
    sem_rsp_t got;
    sem_rsp_t want;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        hit           = out_valid;
        got.status    = status_t'(status);
        got.sem_index = sem_index;
        got.wake      = wake;
        @(posedge clk);
      end while (!hit);
      if (pending_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction: status %0d index %0d wake %0d",
                 $time, got.status, got.sem_index, got.wake);
      end else begin
        want = pending_rsp_q.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, got.status);
        end
        if (got.sem_index !== want.sem_index) begin
          errors++;
          $display("%0t: sem_index mismatch: expected %0d, actual %0d",
                   $time, want.sem_index, got.sem_index);
        end
        if (got.wake !== want.wake) begin
          errors++;
          $display("%0t: wake mismatch: expected %0d, actual %0d",
                   $time, want.wake, got.wake);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    wait_for_responses();
    test_holder_slots_full();
    wait_for_responses();
    test_table_full();
    wait_for_responses();
    release_held();
    wait_for_responses();
    test_refcount_full();
    wait_for_responses();
    test_backpressure();
    wait_for_responses();
    test_random_traffic();
    wait_for_responses();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_rsp_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
